// ----- sv/msgc_pkg.sv -----
// Shared opcodes, status codes and field widths of the color gradient core.
package msgc_pkg;

    localparam int LINE_WIDTH_BITS = 13;
    localparam logic [LINE_WIDTH_BITS-1:0] LINE_WIDTH_RESET = 13'd256;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_INSERT = 2'd1,
        OP_SAMPLE = 2'd2,
        OP_ALT    = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        STAT_SAMPLED  = 2'd0,
        STAT_INSERTED = 2'd1,
        STAT_FULL     = 2'd2,
        STAT_CLEARED  = 2'd3
    } t_status;

endpackage

// ----- sv/msgc_if.sv -----
// Valid/ready channel interfaces for command items and result items.
interface msgc_in_if #(
    parameter int COLUMN_BITS = 12
);
    logic                   valid;
    logic                   ready;
    logic [1:0]             opcode;
    logic [15:0]            stop_position;
    logic [7:0]             stop_red;
    logic [7:0]             stop_green;
    logic [7:0]             stop_blue;
    logic [7:0]             stop_alpha;
    logic [COLUMN_BITS-1:0] pixel_column;

    modport source (output valid, opcode, stop_position, stop_red, stop_green,
                    stop_blue, stop_alpha, pixel_column, input ready);
    modport sink   (input valid, opcode, stop_position, stop_red, stop_green,
                    stop_blue, stop_alpha, pixel_column, output ready);
endinterface

interface msgc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic [1:0] status;
    logic [4:0] stops_held;

    modport source (output valid, out_red, out_green, out_blue, out_alpha, status,
                    stops_held, input ready);
    modport sink   (input valid, out_red, out_green, out_blue, out_alpha, status,
                    stops_held, output ready);
endinterface

// ----- sv/msgc_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
module msgc_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- sv/multi_stop_color_gradient_core.sv -----
// Multi-stop linear color gradient: sorted stop table, sampler and result register.
//
//  channel   | dir | handshake         | payload
//  ----------+-----+-------------------+------------------------------------------
//  i_item    | in  | valid/ready       | opcode, stop_position, stop RGBA, column
//  o_result  | out | valid/ready       | RGBA, status, stops_held
//  i_cfg_*   | in  | write enable only | line_width (13 bits)
//
// Clear, rejected insert and empty-table sample go straight to S_DONE and the result
// register. Insert walks down the table through the one read port of the stop RAM,
// with a read (S_IRD) and a compare (S_ICMP) per stop moved up one slot.
// Sample: the scan costs a RAM read and one pass through the shared multiplier per
// stop, S_SETUP sets up the span, then each channel takes two multiplier passes and
// an 8-step restoring divide.
// Reset (synchronous, active low) empties the table and sets line_width to 256;
// the stop RAM itself is not cleared. One transaction is in work at a time; the
// next is taken while a finished result still waits for o_result.ready.
module multi_stop_color_gradient_core
    import msgc_pkg::*;
#(
    parameter int MAX_STOPS   = 16,
    parameter int COLUMN_BITS = 12
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    msgc_in_if.sink                    i_item,
    msgc_out_if.source                 o_result,
    input  logic                       i_cfg_we,
    input  logic [LINE_WIDTH_BITS-1:0] i_cfg_wdata
);
    localparam int AW = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
    localparam int CW = $clog2(MAX_STOPS + 1);
    localparam int PW = (COLUMN_BITS + 16 > 16 + LINE_WIDTH_BITS) ?
                        COLUMN_BITS + 16 : 16 + LINE_WIDTH_BITS;
    localparam int VW = PW + 8;
    localparam int RW = PW + 9;
    localparam int EW = 48;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_IRD   = 11'b000_0000_0010,
        S_ICMP  = 11'b000_0000_0100,
        S_SRD   = 11'b000_0000_1000,
        S_SMUL  = 11'b000_0001_0000,
        S_SCMP  = 11'b000_0010_0000,
        S_SETUP = 11'b000_0100_0000,
        S_VA    = 11'b000_1000_0000,
        S_VB    = 11'b001_0000_0000,
        S_DIV   = 11'b010_0000_0000,
        S_DONE  = 11'b100_0000_0000
    } t_state;

    t_state                     r_state;
    logic [LINE_WIDTH_BITS-1:0] r_width;
    logic [CW-1:0]              r_count;
    logic [CW-1:0]              r_j;
    logic [CW-1:0]              r_k;
    logic [EW-1:0]              r_new;
    logic [PW-1:0]              r_d;
    logic [PW-1:0]              r_xs;
    logic [31:0]                r_cur_col;
    logic [31:0]                r_prev_col;
    logic [31:0]                r_first_col;
    logic [PW-1:0]              r_mcur;
    logic [PW-1:0]              r_mprev;
    logic [PW-1:0]              r_mfirst;
    logic [31:0]                r_c0;
    logic [31:0]                r_c1;
    logic [PW-1:0]              r_m0;
    logic [PW-1:0]              r_m1;
    logic [PW-1:0]              r_den;
    logic [PW-1:0]              r_num;
    logic [PW-1:0]              r_dmn;
    logic [1:0]                 r_ch;
    logic [VW-1:0]              r_v;
    logic [RW-1:0]              r_rem;
    logic [RW-1:0]              r_dvs;
    logic [2:0]                 r_bit;
    logic [7:0]                 r_q;
    logic [3:0][7:0]            r_res;
    t_status                    r_stat;
    logic                       r_ovalid;
    logic [3:0][7:0]            r_ocol;
    t_status                    r_ostat;
    logic [4:0]                 r_oheld;

    // RAM and shared multiplier
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [EW-1:0]       ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [EW-1:0]       ram_rdata;
    logic [15:0]         mul_a;
    logic [PW-1:0]       mul_b;
    logic [PW+15:0]      mul_p;
    logic [CW-1:0]       j_m1;
    logic [CW-1:0]       k_p1;
    logic [PW-1:0]       den_c;
    logic [PW-1:0]       diff_c;
    logic [PW-1:0]       num_c;
    logic                out_free;
    logic [COLUMN_BITS-1:0] col_x;

    msgc_ram #(.WIDTH(EW), .DEPTH(MAX_STOPS), .AW(AW)) u_stop_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign j_m1     = r_j - 1'b1;
    assign k_p1     = r_k + 1'b1;
    assign out_free = !r_ovalid || o_result.ready;
    assign col_x    = i_item.pixel_column;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_j[AW-1:0];
        ram_wdata = r_new;
        ram_raddr = '0;
        case (r_state)
            S_IRD: begin
                if (r_j == '0) begin
                    ram_we = 1'b1;
                end else begin
                    ram_raddr = j_m1[AW-1:0];
                end
            end
            S_ICMP: begin
                ram_we = 1'b1;
                if (ram_rdata[15:0] > r_new[15:0]) begin
                    ram_wdata = ram_rdata;
                end
            end
            S_SRD: ram_raddr = r_k[AW-1:0];
            default: ;
        endcase
    end

    // one multiplier shared by the table scan and the channel blend
    always_comb begin
        mul_a = ram_rdata[15:0];
        mul_b = r_d;
        case (r_state)
            S_VA: begin
                mul_a = 16'(r_c0[8*r_ch +: 8]);
                mul_b = r_dmn;
            end
            S_VB: begin
                mul_a = 16'(r_c1[8*r_ch +: 8]);
                mul_b = r_num;
            end
            default: ;
        endcase
        mul_p = (PW+16)'(mul_a) * (PW+16)'(mul_b);
    end

    // span and clamped offset of the chosen segment
    always_comb begin
        den_c  = r_m1 - r_m0;
        diff_c = r_xs - r_m0;
        if (r_xs < r_m0) begin
            num_c = '0;
        end else if (diff_c > den_c) begin
            num_c = den_c;
        end else begin
            num_c = diff_c;
        end
        if (r_m1 == r_m0) begin
            den_c = PW'(1);
            num_c = '0;
        end
    end

    assign i_item.ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_width  <= LINE_WIDTH_RESET;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_width <= i_cfg_wdata;
            end
            // drop the result once taken, unless a new one replaces it this cycle
            if (o_result.ready && r_state != S_DONE) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_item.valid) begin
                        r_new <= {i_item.stop_alpha, i_item.stop_blue, i_item.stop_green,
                                  i_item.stop_red, i_item.stop_position};
                        r_j   <= r_count;
                        r_k   <= '0;
                        if (r_width > LINE_WIDTH_BITS'(1)) begin
                            r_d  <= PW'(r_width - 1'b1);
                            r_xs <= PW'({col_x, 16'b0}) - PW'(col_x);
                        end else begin
                            r_d  <= PW'(1);
                            r_xs <= '0;
                        end
                        case (t_opcode'(i_item.opcode))
                            OP_CLEAR: begin
                                r_res   <= '0;
                                r_count <= '0;
                                r_stat  <= STAT_CLEARED;
                                r_state <= S_DONE;
                            end
                            OP_INSERT: begin
                                r_res <= '0;
                                if (r_count >= CW'(MAX_STOPS)) begin
                                    r_stat  <= STAT_FULL;
                                    r_state <= S_DONE;
                                end else begin
                                    r_stat  <= STAT_INSERTED;
                                    r_state <= S_IRD;
                                end
                            end
                            default: begin
                                r_stat <= STAT_SAMPLED;
                                if (r_count == '0) begin
                                    // empty table reads as opaque black
                                    r_res   <= {8'hFF, 8'h00, 8'h00, 8'h00};
                                    r_state <= S_DONE;
                                end else begin
                                    r_state <= S_SRD;
                                end
                            end
                        endcase
                    end
                end
                // walk down from the top, moving each larger stop up one slot
                S_IRD: begin
                    if (r_j == '0) begin
                        r_count <= r_count + 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_ICMP;
                    end
                end
                S_ICMP: begin
                    if (ram_rdata[15:0] > r_new[15:0]) begin
                        r_j     <= j_m1;
                        r_state <= S_IRD;
                    end else begin
                        r_count <= r_count + 1'b1;
                        r_state <= S_DONE;
                    end
                end
                S_SRD: r_state <= S_SMUL;
                S_SMUL: begin
                    r_cur_col <= ram_rdata[47:16];
                    r_mcur    <= mul_p[PW-1:0];
                    r_state   <= S_SCMP;
                end
                // first segment that encloses u, else first and last stop
                S_SCMP: begin
                    if (r_k != '0 && r_mprev <= r_xs && r_xs <= r_mcur) begin
                        r_c0    <= r_prev_col;
                        r_m0    <= r_mprev;
                        r_c1    <= r_cur_col;
                        r_m1    <= r_mcur;
                        r_state <= S_SETUP;
                    end else if (k_p1 == r_count) begin
                        r_c0    <= (r_k == '0) ? r_cur_col : r_first_col;
                        r_m0    <= (r_k == '0) ? r_mcur : r_mfirst;
                        r_c1    <= r_cur_col;
                        r_m1    <= r_mcur;
                        r_state <= S_SETUP;
                    end else begin
                        if (r_k == '0) begin
                            r_first_col <= r_cur_col;
                            r_mfirst    <= r_mcur;
                        end
                        r_prev_col <= r_cur_col;
                        r_mprev    <= r_mcur;
                        r_k        <= k_p1;
                        r_state    <= S_SRD;
                    end
                end
                S_SETUP: begin
                    r_den   <= den_c;
                    r_num   <= num_c;
                    r_dmn   <= den_c - num_c;
                    r_ch    <= '0;
                    r_state <= S_VA;
                end
                S_VA: begin
                    r_v     <= mul_p[VW-1:0];
                    r_state <= S_VB;
                end
                // dividend 2v + den over divisor 2*den rounds half up
                S_VB: begin
                    r_rem   <= {r_v + mul_p[VW-1:0], 1'b0} + RW'(r_den);
                    r_dvs   <= {1'b0, r_den, 8'b0};
                    r_bit   <= 3'd7;
                    r_q     <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_rem >= r_dvs) begin
                        r_rem <= r_rem - r_dvs;
                    end
                    r_q[r_bit] <= (r_rem >= r_dvs);
                    r_dvs      <= r_dvs >> 1;
                    r_bit      <= r_bit - 1'b1;
                    if (r_bit == 3'd0) begin
                        r_res[r_ch] <= {r_q[7:1], (r_rem >= r_dvs)};
                        r_ch        <= r_ch + 1'b1;
                        r_state     <= (r_ch == 2'd3) ? S_DONE : S_VA;
                    end
                end
                // hold until the result register is free
                S_DONE: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_ocol   <= r_res;
                        r_ostat  <= r_stat;
                        r_oheld  <= 5'(r_count);
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_result.valid      = r_ovalid;
    assign o_result.out_red    = r_ocol[0];
    assign o_result.out_green  = r_ocol[1];
    assign o_result.out_blue   = r_ocol[2];
    assign o_result.out_alpha  = r_ocol[3];
    assign o_result.status     = r_ostat;
    assign o_result.stops_held = r_oheld;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_STOPS))
        else $error("stop count above table depth");

    a_div_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> ({1'b0, r_rem} < {r_dvs, 1'b0}))
        else $error("divide remainder out of range");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IRD && r_j == '0) |=> r_count == $past(r_count) + 1'b1)
        else $error("insert did not add a stop");
endmodule

// ----- bench/tb_msgc_scoreboard.sv -----
// Gradient predictor and result checker for the color gradient core bench.
class msgc_scoreboard;
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [1:0] status;
        logic [4:0] stops_held;
    } t_pixel_result;

    localparam int MAX_STOPS = 16;

    bit [15:0]     stop_pos[MAX_STOPS];
    bit [31:0]     stop_rgba[MAX_STOPS];
    int unsigned   stop_total;
    bit [12:0]     line_width;
    t_pixel_result pending[$];
    int unsigned   error_count;

    function new();
        stop_total  = 0;
        line_width  = 13'd256;
        error_count = 0;
    endfunction

    function void set_width(bit [12:0] w);
        line_width = w;
    endfunction

    // Work out the color at column x from the current stop table.
    function void shade(bit [11:0] x, ref t_pixel_result r);
        longint unsigned d;
        longint unsigned xs;
        longint          num;
        longint          den;
        longint          c0;
        longint          c1;
        longint          v;
        int unsigned     i0;
        int unsigned     i1;
        bit [7:0]        ch[4];
        if (stop_total == 0) begin
            r.red = 0; r.green = 0; r.blue = 0; r.alpha = 8'd255;
            return;
        end
        if (line_width > 1) begin
            d  = line_width - 1;
            xs = longint'(x) * 65535;
        end else begin
            d  = 1;
            xs = 0;
        end
        i0 = 0;
        i1 = stop_total - 1;
        for (int i = 0; i + 1 < stop_total; i++) begin
            if (xs >= stop_pos[i] * d && xs <= stop_pos[i+1] * d) begin
                i0 = i;
                i1 = i + 1;
                break;
            end
        end
        if (stop_pos[i1] == stop_pos[i0]) begin
            num = 0;
            den = 1;
        end else begin
            den = (longint'(stop_pos[i1]) - longint'(stop_pos[i0])) * longint'(d);
            num = longint'(xs) - longint'(stop_pos[i0]) * longint'(d);
            if (num < 0) num = 0;
            if (num > den) num = den;
        end
        for (int k = 0; k < 4; k++) begin
            c0 = (stop_rgba[i0] >> (8 * k)) & 8'hFF;
            c1 = (stop_rgba[i1] >> (8 * k)) & 8'hFF;
            v  = c0 * den + (c1 - c0) * num;
            if (v < 0) v = 0;
            ch[k] = 8'((2 * v + den) / (2 * den));
        end
        r.red = ch[0]; r.green = ch[1]; r.blue = ch[2]; r.alpha = ch[3];
    endfunction

    // Note an accepted command and queue the result it must produce.
    function void note_command(msgc_pkg::t_opcode op, bit [15:0] pos, bit [31:0] rgba,
                               bit [11:0] column);
        t_pixel_result r;
        int unsigned   at;
        r = '0;
        case (op)
            msgc_pkg::OP_CLEAR: begin
                stop_total = 0;
                r.status = msgc_pkg::STAT_CLEARED;
            end
            msgc_pkg::OP_INSERT: begin
                if (stop_total >= MAX_STOPS) begin
                    r.status = msgc_pkg::STAT_FULL;
                end else begin
                    at = 0;
                    while (at < stop_total && stop_pos[at] <= pos) at++;
                    for (int j = stop_total; j > at; j--) begin
                        stop_pos[j]  = stop_pos[j-1];
                        stop_rgba[j] = stop_rgba[j-1];
                    end
                    stop_pos[at]  = pos;
                    stop_rgba[at] = rgba;
                    stop_total++;
                    r.status = msgc_pkg::STAT_INSERTED;
                end
            end
            default: begin
                shade(column, r);
                r.status = msgc_pkg::STAT_SAMPLED;
            end
        endcase
        r.stops_held = 5'(stop_total);
        pending.insert(pending.size(), r);
    endfunction

    function void check_result(t_pixel_result got);
        t_pixel_result want;
        if (pending.size() == 0) begin
            $error("result with no command outstanding");
            error_count++;
            return;
        end
        want = pending.pop_front();
        if (got.red !== want.red) begin
            $error("out_red expected %0d got %0d", want.red, got.red); error_count++;
        end
        if (got.green !== want.green) begin
            $error("out_green expected %0d got %0d", want.green, got.green); error_count++;
        end
        if (got.blue !== want.blue) begin
            $error("out_blue expected %0d got %0d", want.blue, got.blue); error_count++;
        end
        if (got.alpha !== want.alpha) begin
            $error("out_alpha expected %0d got %0d", want.alpha, got.alpha); error_count++;
        end
        if (got.status !== want.status) begin
            $error("status expected %0d got %0d", want.status, got.status); error_count++;
        end
        if (got.stops_held !== want.stops_held) begin
            $error("stops_held expected %0d got %0d", want.stops_held, got.stops_held);
            error_count++;
        end
    endfunction
endclass

// ----- bench/tb_multi_stop_color_gradient_core.sv -----
// Self-checking bench for the multi-stop color gradient core.
module tb_multi_stop_color_gradient_core;
    import msgc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic [LINE_WIDTH_BITS-1:0] i_cfg_wdata;

    msgc_in_if  #(.COLUMN_BITS(12)) cmd_bus ();
    msgc_out_if                     res_bus ();

    multi_stop_color_gradient_core #(.MAX_STOPS(16), .COLUMN_BITS(12)) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (cmd_bus),
        .o_result    (res_bus),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    msgc_scoreboard gradient_sb = new();

    // Idling is disabled across a quiet window of the run.
    bit          steady_flow;
    int unsigned accepted_cmds;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Hold results back now and then; check every result transaction.
    initial begin
        res_bus.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_bus.valid && res_bus.ready)
                gradient_sb.check_result({res_bus.out_red, res_bus.out_green, res_bus.out_blue,
                                          res_bus.out_alpha, res_bus.status,
                                          res_bus.stops_held});
            res_bus.ready <= steady_flow || ($urandom_range(0, 99) >= 10);
        end
    end

    // Present one command and hold it until the core takes it.
    task automatic send_command(t_opcode op, bit [15:0] pos, bit [31:0] rgba,
                                bit [11:0] column);
        while (!steady_flow && $urandom_range(0, 99) < 10) begin
            cmd_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_bus.valid         <= 1'b1;
        cmd_bus.opcode        <= op;
        cmd_bus.stop_position <= pos;
        cmd_bus.stop_red      <= rgba[7:0];
        cmd_bus.stop_green    <= rgba[15:8];
        cmd_bus.stop_blue     <= rgba[23:16];
        cmd_bus.stop_alpha    <= rgba[31:24];
        cmd_bus.pixel_column  <= column;
        do @(posedge i_clk); while (!cmd_bus.ready);
        gradient_sb.note_command(op, pos, rgba, column);
        accepted_cmds++;
    endtask

    // Drop the bus, drain results, let the core settle, then write line_width.
    task automatic set_line_width(bit [12:0] w);
        cmd_bus.valid <= 1'b0;
        while (gradient_sb.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= w;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        gradient_sb.set_width(w);
    endtask

    task automatic send_random_command(bit [12:0] w);
        int unsigned pick;
        bit [11:0]   column;
        pick = $urandom_range(0, 99);
        if (w > 1 && $urandom_range(0, 9) != 0)
            column = 12'($urandom_range(0, w - 1));
        else
            column = 12'($urandom);
        if (pick < 3)
            send_command(OP_CLEAR, 0, 0, 0);
        else if (pick < 40)
            send_command(OP_INSERT, ($urandom_range(0, 7) == 0) ? 16'(65535 * $urandom_range(0, 1))
                                                               : 16'($urandom), $urandom, 0);
        else
            send_command(($urandom_range(0, 9) == 0) ? OP_ALT : OP_SAMPLE, 16'($urandom),
                         $urandom, column);
    endtask

    // Runs through the settings, extremes included, then finish.
    initial begin
        bit [12:0] widths[6];
        cmd_bus.valid         = 1'b0;
        cmd_bus.opcode        = OP_CLEAR;
        cmd_bus.stop_position = '0;
        cmd_bus.stop_red      = '0;
        cmd_bus.stop_green    = '0;
        cmd_bus.stop_blue     = '0;
        cmd_bus.stop_alpha    = '0;
        cmd_bus.pixel_column  = '0;
        i_cfg_we              = 1'b0;
        i_cfg_wdata           = '0;
        steady_flow           = 1'b0;
        accepted_cmds         = 0;
        i_rst_n               = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty table, extremes, equal positions, full table, reset width.
        send_command(OP_SAMPLE, 0, 0, 12'd0);
        send_command(OP_INSERT, 16'd0, 32'h00FF00FF, 0);
        send_command(OP_SAMPLE, 0, 0, 12'd255);
        send_command(OP_INSERT, 16'hFFFF, 32'hFF00FF00, 0);
        send_command(OP_INSERT, 16'h8000, 32'h80808080, 0);
        send_command(OP_INSERT, 16'h8000, 32'h10203040, 0);
        send_command(OP_SAMPLE, 0, 0, 12'd128);
        send_command(OP_SAMPLE, 0, 0, 12'd100);
        send_command(OP_ALT, 0, 0, 12'd255);
        send_command(OP_SAMPLE, 0, 0, 12'hFFF);
        for (int i = 0; i < 13; i++)
            send_command(OP_INSERT, 16'($urandom), $urandom, 0);
        send_command(OP_INSERT, 16'h1234, 32'hFFFFFFFF, 0);
        send_command(OP_SAMPLE, 0, 0, 12'd77);
        send_command(OP_CLEAR, 0, 0, 0);

        widths = '{13'd1, 13'd4096, 13'd2, 13'd0, 13'($urandom_range(3, 4095)), 13'd256};
        foreach (widths[p]) begin
            set_line_width(widths[p]);
            for (int n = 0; n < 115; n++) begin
                steady_flow = (p == 2) && (n < 80);
                send_random_command(widths[p]);
            end
        end
        steady_flow = 1'b0;
        cmd_bus.valid <= 1'b0;
        while (gradient_sb.pending.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
        if (gradient_sb.error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #5ms;
        $display("FAILURE");
        $finish;
    end
endmodule
